// ----- src/dpcd_pkg.sv -----
// Shared types and constants for the delta patch command decoder.
// No dependencies; dpcd_parser and delta_patch_command_decoder refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package dpcd_pkg;

    localparam int unsigned LEN_W = 17;
    localparam int unsigned OFF_W = 32;

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_LEN_LO    = 3'd1,
        PH_LEN_HI    = 3'd2,
        PH_OFF_FIRST = 3'd3,
        PH_OFF15     = 3'd4,
        PH_OFF22     = 3'd5,
        PH_OFF32     = 3'd6
    } phase_t;

    localparam logic [1:0] KIND_LITERAL   = 2'd0;
    localparam logic [1:0] KIND_REFERENCE = 2'd1;
    localparam logic [1:0] KIND_ZERO      = 2'd2;

    localparam logic [LEN_W-1:0] LONG_LEN_BIAS = 17'h00081;
    localparam logic [OFF_W-1:0] BIAS15        = 32'h0000_0020;
    localparam logic [OFF_W-1:0] BIAS22        = 32'h0000_4020;
    localparam logic [21:0]      ESCAPE22      = 22'h100000;
    localparam logic [2:0]       OFF22_BYTES   = 3'd2;
    localparam logic [2:0]       OFF32_BYTES   = 3'd4;

    typedef struct packed {
        logic [7:0] patch_byte;
        logic       first_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]       command_kind;
        logic [LEN_W-1:0] copy_length;
        logic [OFF_W-1:0] source_offset;
    } result_t;

endpackage

`default_nettype wire

// ----- src/dpcd_in_if.sv -----
// Byte stream channel into the delta patch command decoder.
// Depends on nothing; valid/ready handshake with the patch byte payload.
`timescale 1ns / 1ps
`default_nettype none

interface dpcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] patch_byte;
    logic       first_byte;

    modport source (output valid, output patch_byte, output first_byte, input ready);
    modport sink   (input valid, input patch_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// ----- src/dpcd_out_if.sv -----
// Copy command channel out of the delta patch command decoder.
// Depends on nothing; valid/ready handshake with the command payload.
`timescale 1ns / 1ps
`default_nettype none

interface dpcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command_kind;
    logic [16:0] copy_length;
    logic [31:0] source_offset;

    modport source (output valid, output command_kind, output copy_length,
                    output source_offset, input ready);
    modport sink   (input valid, input command_kind, input copy_length,
                    input source_offset, output ready);
endinterface

`default_nettype wire

// ----- src/dpcd_parser.sv -----
// Opcode parser: parse state, offset delta decode and base offset tracking.
// Depends on dpcd_pkg; fed one registered byte per cycle by the top level, held while advance is low.
`timescale 1ns / 1ps
`default_nettype none

module dpcd_parser
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire  dpcd_pkg::item_t     item,
    input  wire                       advance,
    input  wire  [dpcd_pkg::OFF_W-1:0] reference_size,
    output logic                      emit,
    output dpcd_pkg::result_t         result
);

    dpcd_pkg::phase_t             phase_reg, phase_next;
    logic [dpcd_pkg::LEN_W-1:0]   plen_reg, plen_next;
    logic [31:0]                  acc_reg, acc_next;
    logic [2:0]                   rem_reg, rem_next;
    logic [dpcd_pkg::OFF_W-1:0]   base_reg, base_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dpcd_pkg::PH_CMD;
            plen_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            base_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            plen_reg  <= plen_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            base_reg  <= base_next;
        end
    end

    always_comb
    begin
        dpcd_pkg::phase_t           ph;
        logic [dpcd_pkg::LEN_W-1:0] plen;
        logic [31:0]                acc;
        logic [2:0]                 rem;
        logic [dpcd_pkg::OFF_W-1:0] base;
        logic [7:0]                 b;
        logic                       finish;
        logic [dpcd_pkg::OFF_W-1:0] delta;
        logic [dpcd_pkg::OFF_W-1:0] off;
        logic [14:0]                v15;
        logic [31:0]                acc22;
        logic [2:0]                 rem_dec;
        logic [31:0]                acc32;

        b = item.patch_byte;
        // first byte of a patch restarts the parser before decoding
        if (item.first_byte)
        begin
            ph   = dpcd_pkg::PH_CMD;
            plen = '0;
            acc  = '0;
            rem  = '0;
            base = '0;
        end
        else
        begin
            ph   = phase_reg;
            plen = plen_reg;
            acc  = acc_reg;
            rem  = rem_reg;
            base = base_reg;
        end

        phase_next = ph;
        plen_next  = plen;
        acc_next   = acc;
        rem_next   = rem;
        base_next  = base;
        emit       = 1'b0;
        result     = '0;
        finish     = 1'b0;
        delta      = '0;
        v15        = {acc[14:8], b};
        rem_dec    = rem - 3'd1;
        acc32      = {acc[23:0], b};
        case (rem_dec)
            3'd0:    acc22 = acc | {24'd0, b};
            3'd1:    acc22 = acc | {16'd0, b, 8'd0};
            3'd2:    acc22 = acc | {8'd0, b, 16'd0};
            3'd3:    acc22 = acc | {b, 24'd0};
            default: acc22 = acc;
        endcase

        case (ph)
            dpcd_pkg::PH_LEN_LO:
            begin
                acc_next   = {24'd0, b};
                phase_next = dpcd_pkg::PH_LEN_HI;
            end
            dpcd_pkg::PH_LEN_HI:
            begin
                plen_next  = {1'b0, b, acc[7:0]} + dpcd_pkg::LONG_LEN_BIAS;
                acc_next   = '0;
                phase_next = dpcd_pkg::PH_OFF_FIRST;
            end
            dpcd_pkg::PH_OFF_FIRST:
            begin
                if (b[7])
                begin
                    if (!b[6])
                    begin
                        finish = 1'b1;
                        delta  = {{26{b[5]}}, b[5:0]};
                    end
                    else
                    begin
                        acc_next   = {10'd0, b[5:0], 16'd0};
                        rem_next   = dpcd_pkg::OFF22_BYTES;
                        phase_next = dpcd_pkg::PH_OFF22;
                    end
                end
                else
                begin
                    acc_next   = {17'd0, b[6:0], 8'd0};
                    phase_next = dpcd_pkg::PH_OFF15;
                end
            end
            dpcd_pkg::PH_OFF15:
            begin
                finish = 1'b1;
                if (v15[14])
                    delta = {{17{1'b1}}, v15} - dpcd_pkg::BIAS15;
                else
                    delta = {17'd0, v15} + dpcd_pkg::BIAS15;
            end
            dpcd_pkg::PH_OFF22:
            begin
                rem_next = rem_dec;
                acc_next = acc22;
                if (rem_dec == 3'd0)
                begin
                    if (acc22 == {10'd0, dpcd_pkg::ESCAPE22})
                    begin
                        // escape: a full 32-bit big-endian delta follows
                        acc_next   = '0;
                        rem_next   = dpcd_pkg::OFF32_BYTES;
                        phase_next = dpcd_pkg::PH_OFF32;
                    end
                    else
                    begin
                        finish = 1'b1;
                        if (acc22[21])
                            delta = {{10{1'b1}}, acc22[21:0]} - dpcd_pkg::BIAS22;
                        else
                            delta = {10'd0, acc22[21:0]} + dpcd_pkg::BIAS22;
                    end
                end
            end
            dpcd_pkg::PH_OFF32:
            begin
                acc_next = acc32;
                rem_next = rem_dec;
                if (rem_dec == 3'd0)
                begin
                    finish = 1'b1;
                    delta  = acc32;
                end
            end
            default:
            begin
                // command byte
                phase_next = dpcd_pkg::PH_CMD;
                acc_next   = '0;
                rem_next   = '0;
                if (b[7])
                begin
                    emit                = 1'b1;
                    result.command_kind = dpcd_pkg::KIND_LITERAL;
                    if (b[6:5] == 2'd0)
                    begin
                        result.copy_length = {12'd0, b[4:0]} + 17'd1;
                    end
                    else
                    begin
                        result.copy_length = {15'd0, b[6:5]};
                        plen_next          = {12'd0, b[4:0]} + 17'd2;
                        phase_next         = dpcd_pkg::PH_OFF_FIRST;
                    end
                end
                else if (b == 8'd0)
                begin
                    phase_next = dpcd_pkg::PH_LEN_LO;
                end
                else
                begin
                    plen_next  = {9'd0, b} + 17'd1;
                    phase_next = dpcd_pkg::PH_OFF_FIRST;
                end
            end
        endcase

        off = base + delta;
        if (finish)
        begin
            emit               = 1'b1;
            result.copy_length = plen;
            if (off < reference_size)
            begin
                result.command_kind  = dpcd_pkg::KIND_REFERENCE;
                result.source_offset = off;
            end
            else
            begin
                result.command_kind  = dpcd_pkg::KIND_ZERO;
                result.source_offset = '0;
            end
            base_next  = base + delta + {15'd0, plen};
            phase_next = dpcd_pkg::PH_CMD;
            acc_next   = '0;
            rem_next   = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/delta_patch_command_decoder.sv -----
// Delta patch command decoder: takes the patch opcode stream one byte per
// transaction and returns at most one copy command per byte. Throughput is one
// byte per clock while no command stalls; a command reaches the output through
// the input register, then the parser logic into the result register. A full
// result register stalls only a byte that would produce a command. Write
// reference_size through cfg_wr_en/cfg_wr_data only while the block is idle.
// Depends on dpcd_pkg, dpcd_in_if, dpcd_out_if and dpcd_parser.
`timescale 1ns / 1ps
`default_nettype none

module delta_patch_command_decoder
(
    input  wire         clk,
    input  wire         rst_n,
    dpcd_in_if.sink     cmd_stream,
    dpcd_out_if.source  copy_cmd,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data
);

    logic                       in_valid_reg, in_valid_next;
    dpcd_pkg::item_t            in_item_reg;
    logic                       out_valid_reg, out_valid_next;
    dpcd_pkg::result_t          out_result_reg;
    logic [dpcd_pkg::OFF_W-1:0] ref_size_reg;
    logic                       emit;
    logic                       advance;
    dpcd_pkg::result_t          result;

    dpcd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (in_item_reg),
        .advance        (advance),
        .reference_size (ref_size_reg),
        .emit           (emit),
        .result         (result)
    );

    // hold the byte only if its command has nowhere to go
    assign advance          = in_valid_reg && (!emit || !out_valid_reg || copy_cmd.ready);
    assign cmd_stream.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = cmd_stream.ready ? cmd_stream.valid : in_valid_reg;
        if (advance && emit)
            out_valid_next = 1'b1;
        else if (copy_cmd.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ref_size_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                ref_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_stream.ready && cmd_stream.valid)
        begin
            in_item_reg.patch_byte <= cmd_stream.patch_byte;
            in_item_reg.first_byte <= cmd_stream.first_byte;
        end
        if (advance && emit)
            out_result_reg <= result;
    end

    assign copy_cmd.valid         = out_valid_reg;
    assign copy_cmd.command_kind  = out_result_reg.command_kind;
    assign copy_cmd.copy_length   = out_result_reg.copy_length;
    assign copy_cmd.source_offset = out_result_reg.source_offset;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for delta_patch_command_decoder: drives patch bytes,
// predicts every copy command and checks each one at the output handshake.
// Depends on dpcd_pkg, dpcd_in_if, dpcd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned NUM_SIZES       = 5;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned MAX_WAIT        = 17;

    typedef enum int unsigned {DELTA6, DELTA15, DELTA22, DELTA32} delta_form_t;
    typedef enum int unsigned {CMD_LITERAL, CMD_LITERAL_REF, CMD_SHORT_REF, CMD_LONG_REF}
        cmd_form_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    dpcd_in_if  cmd_stream ();
    dpcd_out_if copy_cmd ();

    delta_patch_command_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_stream  (cmd_stream),
        .copy_cmd    (copy_cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // stimulus and expectations
    dpcd_pkg::item_t   patch_bytes [$];
    dpcd_pkg::result_t expected_cmds [$];
    logic        no_idle     = 1'b0;
    logic        force_first = 1'b0;
    int unsigned phase_bytes = 0;
    int unsigned bytes_taken = 0;
    int unsigned errors      = 0;
    int unsigned cycles      = 0;
    int unsigned kind_seen [3] = '{0, 0, 0};
    int unsigned src_wait;
    int unsigned sink_wait;

    // decoder shadow state
    dpcd_pkg::phase_t ph   = dpcd_pkg::PH_CMD;
    logic [16:0] pend_len  = '0;
    logic [31:0] acc       = '0;
    logic [2:0]  remaining = '0;
    logic [31:0] base      = '0;
    logic [31:0] ref_size  = '0;

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void push_cmd(input logic [1:0] kind, input logic [16:0] len,
                                     input logic [31:0] off);
        dpcd_pkg::result_t r;
        r.command_kind  = kind;
        r.copy_length   = len;
        r.source_offset = off;
        expected_cmds.insert(expected_cmds.size(), r);
    endfunction

    // sign bit set: extend and subtract the bias, else add it
    function automatic logic [31:0] bias_delta(input logic [31:0] v, input int sbit,
                                               input logic [31:0] bias);
        if (v[sbit])
            return (v | (32'hffff_ffff << sbit)) - bias;
        return v + bias;
    endfunction

    function automatic void close_reference(input logic [31:0] delta);
        logic [31:0] start;
        start = base + delta;
        if (start < ref_size)
            push_cmd(dpcd_pkg::KIND_REFERENCE, pend_len, start);
        else
            push_cmd(dpcd_pkg::KIND_ZERO, pend_len, '0);
        base      = base + delta + {15'd0, pend_len};
        ph        = dpcd_pkg::PH_CMD;
        acc       = '0;
        remaining = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fb);
        if (fb)
        begin
            base      = '0;
            ph        = dpcd_pkg::PH_CMD;
            pend_len  = '0;
            acc       = '0;
            remaining = '0;
        end
        case (ph)
            dpcd_pkg::PH_LEN_LO:
            begin
                acc = {24'd0, b};
                ph  = dpcd_pkg::PH_LEN_HI;
            end
            dpcd_pkg::PH_LEN_HI:
            begin
                pend_len = {1'b0, b, acc[7:0]} + dpcd_pkg::LONG_LEN_BIAS;
                acc      = '0;
                ph       = dpcd_pkg::PH_OFF_FIRST;
            end
            dpcd_pkg::PH_OFF_FIRST:
            begin
                if (b[7] && !b[6])
                    close_reference(bias_delta({26'd0, b[5:0]}, 5, '0));
                else if (b[7])
                begin
                    acc       = {10'd0, b[5:0], 16'd0};
                    remaining = dpcd_pkg::OFF22_BYTES;
                    ph        = dpcd_pkg::PH_OFF22;
                end
                else
                begin
                    acc = {17'd0, b[6:0], 8'd0};
                    ph  = dpcd_pkg::PH_OFF15;
                end
            end
            dpcd_pkg::PH_OFF15:
                close_reference(bias_delta(acc | {24'd0, b}, 14, dpcd_pkg::BIAS15));
            dpcd_pkg::PH_OFF22:
            begin
                remaining = remaining - 3'd1;
                acc = acc | ({24'd0, b} << {remaining, 3'b000});
                if (remaining == 3'd0)
                begin
                    if (acc == {10'd0, dpcd_pkg::ESCAPE22})
                    begin
                        acc       = '0;
                        remaining = dpcd_pkg::OFF32_BYTES;
                        ph        = dpcd_pkg::PH_OFF32;
                    end
                    else
                        close_reference(bias_delta(acc, 21, dpcd_pkg::BIAS22));
                end
            end
            dpcd_pkg::PH_OFF32:
            begin
                acc       = {acc[23:0], b};
                remaining = remaining - 3'd1;
                if (remaining == 3'd0)
                    close_reference(acc);
            end
            default:
            begin
                // command byte
                ph        = dpcd_pkg::PH_CMD;
                acc       = '0;
                remaining = '0;
                if (b[7] && b[6:5] == 2'd0)
                    push_cmd(dpcd_pkg::KIND_LITERAL, {12'd0, b[4:0]} + 17'd1, '0);
                else if (b[7])
                begin
                    push_cmd(dpcd_pkg::KIND_LITERAL, {15'd0, b[6:5]}, '0);
                    pend_len = {12'd0, b[4:0]} + 17'd2;
                    ph       = dpcd_pkg::PH_OFF_FIRST;
                end
                else if (b == 8'h00)
                    ph = dpcd_pkg::PH_LEN_LO;
                else
                begin
                    pend_len = {9'd0, b} + 17'd1;
                    ph       = dpcd_pkg::PH_OFF_FIRST;
                end
            end
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic fb);
        dpcd_pkg::item_t it;
        it.patch_byte = b;
        it.first_byte = fb;
        patch_bytes.insert(patch_bytes.size(), it);
        phase_bytes++;
    endtask

    task automatic put_offset(input delta_form_t form);
        logic [31:0] delta;
        case (form)
            DELTA6:
                put_byte({2'b10, 6'($urandom)}, 1'b0);
            DELTA15:
            begin
                put_byte({1'b0, 7'($urandom)}, 1'b0);
                put_byte(8'($urandom), 1'b0);
            end
            DELTA22:
            begin
                put_byte({2'b11, 6'($urandom)}, 1'b0);
                put_byte(8'($urandom), 1'b0);
                put_byte(8'($urandom), 1'b0);
            end
            default:
            begin
                // half full-range, half small signed steps around the base
                if ($urandom_range(0, 1) == 0)
                    delta = $urandom;
                else
                    delta = 32'($urandom_range(0, 32'hffff)) - 32'h8000;
                put_byte({2'b11, dpcd_pkg::ESCAPE22[21:16]}, 1'b0);
                put_byte(dpcd_pkg::ESCAPE22[15:8], 1'b0);
                put_byte(dpcd_pkg::ESCAPE22[7:0], 1'b0);
                put_byte(delta[31:24], 1'b0);
                put_byte(delta[23:16], 1'b0);
                put_byte(delta[15:8], 1'b0);
                put_byte(delta[7:0], 1'b0);
            end
        endcase
    endtask

    // mostly well-formed commands; some noise and some cut short by a first byte
    task automatic put_random_command();
        int unsigned pick;
        cmd_form_t   form;
        logic        fb;
        pick = $urandom_range(0, 99);
        fb = force_first || ($urandom_range(0, 7) == 0);
        force_first = 1'b0;
        if (pick < 6)
            put_byte(8'($urandom), $urandom_range(0, 3) == 0);
        else
        begin
            form = cmd_form_t'($urandom_range(0, 3));
            case (form)
                CMD_LITERAL:
                    put_byte({3'b100, 5'($urandom)}, fb);
                CMD_LITERAL_REF:
                    put_byte({1'b1, 2'($urandom_range(1, 3)), 5'($urandom)}, fb);
                CMD_SHORT_REF:
                    put_byte({1'b0, 7'($urandom_range(1, 127))}, fb);
                default:
                begin
                    put_byte(8'h00, fb);
                    put_byte(8'($urandom), 1'b0);
                    put_byte(8'($urandom), 1'b0);
                end
            endcase
            if (form != CMD_LITERAL && pick < 14)
            begin
                repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0);
                force_first = 1'b1;
            end
            else if (form != CMD_LITERAL)
                put_offset(delta_form_t'($urandom_range(0, 3)));
        end
    endtask

    task automatic set_ref_size(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        ref_size = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (patch_bytes.size() != 0 || cmd_stream.valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        dpcd_pkg::item_t nxt;
        if (!rst_n)
        begin
            cmd_stream.valid      <= 1'b0;
            cmd_stream.patch_byte <= '0;
            cmd_stream.first_byte <= 1'b0;
            src_wait              <= 0;
        end
        else
        begin
            if (cmd_stream.valid && cmd_stream.ready)
            begin
                decode_byte(cmd_stream.patch_byte, cmd_stream.first_byte);
                bytes_taken++;
            end
            if (cmd_stream.valid && !cmd_stream.ready)
            begin
                // hold the transaction until it is taken
            end
            else if (src_wait != 0)
            begin
                src_wait         <= src_wait - 1;
                cmd_stream.valid <= 1'b0;
            end
            else if (patch_bytes.size() != 0)
            begin
                nxt = patch_bytes.pop_front();
                cmd_stream.patch_byte <= nxt.patch_byte;
                cmd_stream.first_byte <= nxt.first_byte;
                cmd_stream.valid      <= 1'b1;
                src_wait              <= draw_wait();
            end
            else
                cmd_stream.valid <= 1'b0;
        end
    end

    // command monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : check_cmds
        dpcd_pkg::result_t want;
        int unsigned       stall;
        if (!rst_n)
        begin
            copy_cmd.ready <= 1'b0;
            sink_wait      <= 0;
        end
        else
        begin
            if (copy_cmd.valid && copy_cmd.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected command kind %0d length %0d offset %h", $time,
                             copy_cmd.command_kind, copy_cmd.copy_length, copy_cmd.source_offset);
                    errors++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (want.command_kind < 3)
                        kind_seen[want.command_kind]++;
                    if (copy_cmd.command_kind !== want.command_kind)
                    begin
                        $display("%0t: command_kind expected %0d, got %0d", $time,
                                 want.command_kind, copy_cmd.command_kind);
                        errors++;
                    end
                    if (copy_cmd.copy_length !== want.copy_length)
                    begin
                        $display("%0t: copy_length expected %0d, got %0d", $time,
                                 want.copy_length, copy_cmd.copy_length);
                        errors++;
                    end
                    if (copy_cmd.source_offset !== want.source_offset)
                    begin
                        $display("%0t: source_offset expected %h, got %h", $time,
                                 want.source_offset, copy_cmd.source_offset);
                        errors++;
                    end
                end
                stall = draw_wait();
                sink_wait      <= stall;
                copy_cmd.ready <= (stall == 0);
            end
            else if (sink_wait != 0)
            begin
                sink_wait      <= sink_wait - 1;
                copy_cmd.ready <= (sink_wait == 1);
            end
            else
                copy_cmd.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d commands still outstanding", $time,
                     expected_cmds.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : run
        logic [31:0] size_list [NUM_SIZES];
        cmd_stream.valid      = 1'b0;
        cmd_stream.patch_byte = '0;
        cmd_stream.first_byte = 1'b0;
        copy_cmd.ready        = 1'b0;
        rst_n                 = 1'b0;
        size_list[0] = 32'hffff_ffff;
        size_list[1] = 32'h0000_0000;
        size_list[2] = $urandom;
        size_list[3] = 32'h0001_0000;
        size_list[4] = 32'h8000_0000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_ref_size(32'h0000_2000);
        put_byte(8'h80, 1'b1);      // shortest literal
        put_byte(8'h9f, 1'b0);      // longest literal
        put_byte(8'hff, 1'b0);      // literal 3 then copy of 33, delta -1 wraps: zero fill
        put_byte(8'hbf, 1'b0);
        put_byte(8'h00, 1'b1);      // longest long copy, 15-bit delta all ones
        put_byte(8'hff, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h7f, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b1);      // shortest long copy, 15-bit delta of zero plus bias
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b0);      // short copy, positive 22-bit delta
        put_byte(8'hc0, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h05, 1'b0);
        put_byte(8'h7f, 1'b1);      // escaped delta to the last byte: runs past the end
        put_byte({2'b11, dpcd_pkg::ESCAPE22[21:16]}, 1'b0);
        put_byte(dpcd_pkg::ESCAPE22[15:8], 1'b0);
        put_byte(dpcd_pkg::ESCAPE22[7:0], 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h1f, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);      // long copy cut off by a new first byte
        put_byte(8'h12, 1'b0);
        put_byte(8'ha1, 1'b1);
        put_byte(8'h80, 1'b0);
        wait_drained();

        for (int p = 0; p < NUM_SIZES; p++)
        begin
            set_ref_size(size_list[p]);
            no_idle     = (p == 2);
            phase_bytes = 0;
            while (phase_bytes < ITEMS_PER_PHASE)
                put_random_command();
            wait_drained();
        end
        no_idle = 1'b0;

        $display("Covered %0d patch bytes across %0d reference sizes plus a directed set.",
                 bytes_taken, NUM_SIZES + 1);
        $display("Checked %0d literal, %0d reference and %0d zero fill commands.",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
